// ===== rtl/lehmer_rng_skip_ahead_top_assert.svh =====
// assertion macros shared by the checker of the skip-ahead random stream
`ifndef LEHMER_RNG_SKIP_AHEAD_TOP_ASSERT_SVH
`define LEHMER_RNG_SKIP_AHEAD_TOP_ASSERT_SVH

// antecedent in one cycle implies consequent in the next, ignored while in reset
`define LRSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// same form, but also checked across the reset cycle itself
`define LRSA_ASSERT_NEXT_NORST(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lrsa_pkg.sv =====
// types, constants and codes of the skip-ahead random stream
`default_nettype none

package lrsa_pkg;

   // generator constants: modulus 2^31-1 and minimal standard multiplier
   localparam logic [30:0] LCG_MOD = 31'h7FFF_FFFF;
   localparam logic [30:0] LCG_MUL = 31'd16807;

   // register reset values
   localparam logic [30:0] INIT_SEED_RESET = 31'd19620718;
   localparam logic [15:0] SPR_RESET       = 16'd1;

   // default width of the row count that is honoured
   localparam int ROW_COUNT_BITS_DEF = 32;

   // register port
   localparam int CSR_INDEX_BITS = 8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INITIAL_SEED  = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DRAWS_PER_ROW = 8'd1;

   // operation codes
   localparam logic [1:0] OP_NEXT  = 2'd0;
   localparam logic [1:0] OP_SKIP  = 2'd1;
   localparam logic [1:0] OP_RESET = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] skip_rows;
   } req_type;

   typedef struct packed {
      logic [30:0] value;
      logic [31:0] seeds_used;
   } rsp_type;

   typedef struct packed {
      logic [30:0] initial_seed;
      logic [15:0] draws_per_row;
   } cfg_type;

   // modular multiplier request and response
   typedef struct packed {
      logic        start;
      logic [30:0] a;
      logic [30:0] b;
   } mm_req_type;

   typedef struct packed {
      logic        done;
      logic [30:0] prod;
   } mm_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NEXT_WAIT,
      ST_DIST,
      ST_STEP,
      ST_ACC_WAIT,
      ST_SQR_WAIT,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/lrsa_modmul.sv =====
// two-stage multiplier modulo 2^31-1: product register, then end-around fold
`default_nettype none

module lrsa_modmul
   import lrsa_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire mm_req_type mm_req,
   output mm_rsp_type      mm_rsp
);

   logic        stage1_ff;
   logic        done_ff;
   logic [61:0] prod_ff;
   logic [30:0] res_ff;
   logic [31:0] fold_sum;
   logic [31:0] fold_wrap;
   logic [30:0] res_in;

   // fold high half onto low half, wrap the carry, then one conditional subtract
   always_comb begin
      fold_sum  = {1'b0, prod_ff[61:31]} + {1'b0, prod_ff[30:0]};
      fold_wrap = {1'b0, fold_sum[30:0]} + {31'd0, fold_sum[31]};
      if (fold_wrap >= {1'b0, LCG_MOD}) begin
         res_in = fold_wrap[30:0] - LCG_MOD;
      end else begin
         res_in = fold_wrap[30:0];
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= {31'd0, mm_req.a} * {31'd0, mm_req.b};
      res_ff  <= res_in;
   end

   // stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         stage1_ff <= mm_req.start;
         done_ff   <= stage1_ff;
      end
   end

   assign mm_rsp.done = done_ff;
   assign mm_rsp.prod = res_ff;

endmodule

`default_nettype wire

// ===== rtl/lrsa_seq.sv =====
// sequencer and state of the stream: next, square-and-multiply skip, reset
`default_nettype none

module lrsa_seq
   import lrsa_pkg::*;
#(
   parameter int ROW_COUNT_BITS = ROW_COUNT_BITS_DEF
)(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   input  wire cfg_type    cfg,
   input  wire logic       out_free,
   output logic            out_load,
   output rsp_type         out_data,
   output mm_req_type      mm_req,
   input  wire mm_rsp_type mm_rsp
);

   localparam int ROW_BITS  = (ROW_COUNT_BITS < 32) ? ROW_COUNT_BITS : 32;
   localparam int DIST_BITS = ROW_BITS + 16;

   state_type             state_ff, state_in;
   logic [ROW_BITS-1:0]   rows_ff, rows_in;
   logic [DIST_BITS-1:0]  dist_ff, dist_in;
   logic [DIST_BITS-1:0]  dist_prod;
   logic [30:0]           seed_ff, seed_in;
   logic [31:0]           count_ff, count_in;
   logic [30:0]           acc_ff, acc_in;
   logic [30:0]           pow_ff, pow_in;
   logic                  accept;

   assign accept    = req_valid && req_ready;
   assign dist_prod = DIST_BITS'(rows_ff) * DIST_BITS'(cfg.draws_per_row);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.op)
                  OP_NEXT: state_in = ST_NEXT_WAIT;
                  OP_SKIP: state_in = ST_DIST;
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_NEXT_WAIT: begin
            if (mm_rsp.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_DIST: state_in = ST_STEP;
         ST_STEP: begin
            if (dist_ff == '0) begin
               state_in = ST_FINISH;
            end else if (dist_ff[0]) begin
               state_in = ST_ACC_WAIT;
            end else begin
               state_in = ST_SQR_WAIT;
            end
         end
         ST_ACC_WAIT: begin
            if (mm_rsp.done) begin
               state_in = ST_SQR_WAIT;
            end
         end
         ST_SQR_WAIT: begin
            if (mm_rsp.done) begin
               state_in = ST_STEP;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs: handshake, multiplier issue, result load
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      out_load     = 1'b0;
      mm_req.start = 1'b0;
      mm_req.a     = pow_ff;
      mm_req.b     = pow_ff;
      case (state_ff)
         ST_IDLE: begin
            mm_req.start = accept && (req_data.op == OP_NEXT);
            mm_req.a     = LCG_MUL;
            mm_req.b     = seed_ff;
         end
         ST_STEP: begin
            mm_req.start = (dist_ff != '0);
            mm_req.b     = dist_ff[0] ? acc_ff : pow_ff;
         end
         ST_ACC_WAIT: mm_req.start = mm_rsp.done;
         ST_FINISH:   out_load     = out_free;
         default: ;
      endcase
   end

   assign out_data.value      = seed_ff;
   assign out_data.seeds_used = count_ff;

   // datapath updates
   always_comb begin
      rows_in  = rows_ff;
      dist_in  = dist_ff;
      seed_in  = seed_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      pow_in   = pow_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rows_in = req_data.skip_rows[ROW_BITS-1:0];
               case (req_data.op)
                  OP_SKIP: begin
                     acc_in = cfg.initial_seed;
                     pow_in = LCG_MUL;
                  end
                  OP_RESET: begin
                     seed_in  = cfg.initial_seed;
                     count_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_NEXT_WAIT: begin
            if (mm_rsp.done) begin
               seed_in = mm_rsp.prod;
               if (count_ff != '1) begin
                  count_in = count_ff + 32'd1;
               end
            end
         end
         ST_DIST: dist_in = dist_prod;
         ST_STEP: begin
            if (dist_ff == '0) begin
               seed_in  = acc_ff;
               count_in = '0;
            end
         end
         ST_ACC_WAIT: begin
            if (mm_rsp.done) begin
               acc_in = mm_rsp.prod;
            end
         end
         ST_SQR_WAIT: begin
            if (mm_rsp.done) begin
               pow_in  = mm_rsp.prod;
               dist_in = dist_ff >> 1;
            end
         end
         default: ;
      endcase
   end

   // control and stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seed_ff  <= INIT_SEED_RESET;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         seed_ff  <= seed_in;
         count_ff <= count_in;
      end
   end

   // working registers of an item
   always_ff @(posedge clock) begin
      rows_ff <= rows_in;
      dist_ff <= dist_in;
      acc_ff  <= acc_in;
      pow_ff  <= pow_in;
   end

endmodule

`default_nettype wire

// ===== rtl/lehmer_rng_skip_ahead_top.sv =====
// top level of the skip-ahead random stream: registers, result register, sequencer and multiplier
`default_nettype none

// Park-Miller minimal standard stream (seed' = 16807 * seed mod 2^31-1) with three
// operations: next draws a value and bumps a saturating use count, skip jumps to
// initial_seed * 16807^(skip_rows * draws_per_row) by square-and-multiply and clears
// the count, reset reloads initial_seed and clears the count. Every item gives one
// result carrying the seed and the count. One item is in work at a time; a finished
// result waits in an output register so the next item can start. All modular
// products go through a single two-stage multiplier with end-around fold. Skip
// squares once for each bit of a skip distance of up to min(ROW_COUNT_BITS, 32) + 16
// bits and multiplies into the result once for each one bit. Register writes are
// taken at any time and act on the next operation that reads them.
module lehmer_rng_skip_ahead_top
   import lrsa_pkg::*;
#(
   parameter int ROW_COUNT_BITS = ROW_COUNT_BITS_DEF
)(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire req_type                   req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output rsp_type                        rsp_data,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [31:0]               csr_data
);

   logic [30:0] init_seed_ff;
   logic [15:0] spr_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   cfg_type     cfg;
   logic        out_free;
   logic        out_load;
   rsp_type     out_data;
   mm_req_type  mm_req;
   mm_rsp_type  mm_rsp;

   // register writes, masked to register widths
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_seed_ff <= INIT_SEED_RESET;
         spr_ff       <= SPR_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_INITIAL_SEED:  init_seed_ff <= csr_data[30:0];
            CSR_DRAWS_PER_ROW: spr_ff       <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   assign cfg.initial_seed  = init_seed_ff;
   assign cfg.draws_per_row = spr_ff;

   // result register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= out_load;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= out_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer and shared multiplier
   lrsa_seq #(
      .ROW_COUNT_BITS(ROW_COUNT_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .out_free  (out_free),
      .out_load  (out_load),
      .out_data  (out_data),
      .mm_req    (mm_req),
      .mm_rsp    (mm_rsp)
   );

   lrsa_modmul u_modmul (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req),
      .mm_rsp (mm_rsp)
   );

endmodule

`default_nettype wire

// ===== rtl/lrsa_checker.sv =====
// port-level checks on the skip-ahead random stream, bound to its top level
`default_nettype none

`include "lehmer_rng_skip_ahead_top_assert.svh"

module lrsa_checker
   import lrsa_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // a stalled result holds
   `LRSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed or dropped")

   // one item in work at a time
   `LRSA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "block ready again right after taking an item")

   // reset leaves the block idle and empty
   `LRSA_ASSERT_NEXT_NORST(a_reset_idle, clock, reset, !rsp_valid && req_ready, "block not idle after reset")

endmodule

bind lehmer_rng_skip_ahead_top lrsa_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
